// ===== rtl/cfs_pkg.sv =====
// Shared types and constants for the cube-map face selection block.
package cfs_pkg;

   localparam int FACE_WIDTH = 3;

   // Face codes in the order of the usual cube-map layout.
   localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd5;

   // Control that travels alongside the divider data through the cell chain.
   typedef struct packed {
      logic [FACE_WIDTH-1:0] face;
      logic                  zero;
      logic                  sat_u;
      logic                  sat_v;
   } cfs_tag_type;

endpackage

// ===== rtl/cfs_if.sv =====
// Valid/ready channel interfaces for the direction words and the face words.
interface cfs_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;

   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cfs_rsp_if #(
   parameter int UV_WIDTH = 16
);
   logic                            valid;
   logic                            ready;
   logic [cfs_pkg::FACE_WIDTH-1:0]  face_id;
   logic [UV_WIDTH-1:0]             tex_u;
   logic [UV_WIDTH-1:0]             tex_v;
   logic                            zero_direction;

   modport source (output valid, output face_id, output tex_u, output tex_v,
                   output zero_direction, input ready);
   modport sink   (input valid, input face_id, input tex_u, input tex_v,
                   input zero_direction, output ready);
endinterface

// ===== rtl/cfs_front.sv =====
// Front stage: major axis pick, face code and division operands, registered.
module cfs_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] dir_x,
   input  logic signed [COORD_WIDTH-1:0] dir_y,
   input  logic signed [COORD_WIDTH-1:0] dir_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cfs_pkg::cfs_tag_type          out_tag,
   output logic [COORD_WIDTH-1:0]        out_ma,
   output logic [COORD_WIDTH:0]          out_num_u,
   output logic [COORD_WIDTH:0]          out_num_v
);

   localparam int CW = COORD_WIDTH;

   logic signed [CW:0]   x_ext, y_ext, z_ext;
   logic signed [CW:0]   x_neg, y_neg, z_neg;
   logic signed [CW:0]   ax_w, ay_w, az_w;
   logic [CW-1:0]        ax, ay, az;
   logic [CW-1:0]        ma;
   logic signed [CW:0]   sc, tc;
   logic signed [CW+1:0] num_u_w, num_v_w;
   logic [cfs_pkg::FACE_WIDTH-1:0] face;
   cfs_pkg::cfs_tag_type tag;

   logic                 valid_ff, valid_in;
   cfs_pkg::cfs_tag_type tag_ff;
   logic [CW-1:0]        ma_ff;
   logic [CW:0]          num_u_ff, num_v_ff;

   always_comb begin
      x_ext = {dir_x[CW-1], dir_x};
      y_ext = {dir_y[CW-1], dir_y};
      z_ext = {dir_z[CW-1], dir_z};
      x_neg = -x_ext;
      y_neg = -y_ext;
      z_neg = -z_ext;
      // The most negative input has magnitude 2^(CW-1), which still fits CW bits.
      ax_w = dir_x[CW-1] ? x_neg : x_ext;
      ay_w = dir_y[CW-1] ? y_neg : y_ext;
      az_w = dir_z[CW-1] ? z_neg : z_ext;
      ax = ax_w[CW-1:0];
      ay = ay_w[CW-1:0];
      az = az_w[CW-1:0];

      priority if (ax > ay && ax > az) begin
         ma = ax;
         tc = y_neg;
         if (x_ext > 0) begin
            face = cfs_pkg::FACE_POS_X;
            sc   = z_neg;
         end else begin
            face = cfs_pkg::FACE_NEG_X;
            sc   = z_ext;
         end
      end else if (ay > az) begin
         ma = ay;
         sc = x_ext;
         if (y_ext > 0) begin
            face = cfs_pkg::FACE_POS_Y;
            tc   = z_ext;
         end else begin
            face = cfs_pkg::FACE_NEG_Y;
            tc   = z_neg;
         end
      end else begin
         ma = az;
         tc = y_neg;
         if (z_ext > 0) begin
            face = cfs_pkg::FACE_POS_Z;
            sc   = x_ext;
         end else begin
            face = cfs_pkg::FACE_NEG_Z;
            sc   = x_neg;
         end
      end

      // Numerators sc + ma lie in 0 .. 2*ma, so they fit CW+1 unsigned bits.
      num_u_w = {sc[CW], sc} + $signed({2'b00, ma});
      num_v_w = {tc[CW], tc} + $signed({2'b00, ma});

      tag.face  = face;
      tag.zero  = (ma == '0);
      tag.sat_u = (sc == $signed({1'b0, ma}));
      tag.sat_v = (tc == $signed({1'b0, ma}));
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tag_ff   <= tag;
         ma_ff    <= ma;
         num_u_ff <= num_u_w[CW:0];
         num_v_ff <= num_v_w[CW:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_ma    = ma_ff;
   assign out_num_u = num_u_ff;
   assign out_num_v = num_v_ff;

endmodule

// ===== rtl/cfs_div_cell.sv =====
// One divider cell: retires one quotient bit of u and of v per word.
module cfs_div_cell #(
   parameter int COORD_WIDTH = 16,
   parameter int UV_WIDTH    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cfs_pkg::cfs_tag_type   in_tag,
   input  logic [COORD_WIDTH-1:0] in_ma,
   input  logic [COORD_WIDTH:0]   in_rem_u,
   input  logic [COORD_WIDTH:0]   in_rem_v,
   input  logic [UV_WIDTH-1:0]    in_quo_u,
   input  logic [UV_WIDTH-1:0]    in_quo_v,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cfs_pkg::cfs_tag_type   out_tag,
   output logic [COORD_WIDTH-1:0] out_ma,
   output logic [COORD_WIDTH:0]   out_rem_u,
   output logic [COORD_WIDTH:0]   out_rem_v,
   output logic [UV_WIDTH-1:0]    out_quo_u,
   output logic [UV_WIDTH-1:0]    out_quo_v
);

   localparam int CW = COORD_WIDTH;
   localparam int UV = UV_WIDTH;

   logic [CW:0]  ma_ext;
   logic         ge_u, ge_v;
   logic [CW:0]  diff_u, diff_v;

   logic                 valid_ff, valid_in;
   cfs_pkg::cfs_tag_type tag_ff;
   logic [CW-1:0]        ma_ff;
   logic [CW:0]          rem_u_ff, rem_v_ff;
   logic [UV-1:0]        quo_u_ff, quo_v_ff;

   // Restoring step: remainder below 2*ma in, below 2*ma out after the shift.
   always_comb begin
      ma_ext = {1'b0, in_ma};
      ge_u   = (in_rem_u >= ma_ext);
      ge_v   = (in_rem_v >= ma_ext);
      diff_u = ge_u ? (in_rem_u - ma_ext) : in_rem_u;
      diff_v = ge_v ? (in_rem_v - ma_ext) : in_rem_v;
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tag_ff   <= in_tag;
         ma_ff    <= in_ma;
         rem_u_ff <= {diff_u[CW-1:0], 1'b0};
         rem_v_ff <= {diff_v[CW-1:0], 1'b0};
         quo_u_ff <= {in_quo_u[UV-2:0], ge_u};
         quo_v_ff <= {in_quo_v[UV-2:0], ge_v};
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_ma    = ma_ff;
   assign out_rem_u = rem_u_ff;
   assign out_rem_v = rem_v_ff;
   assign out_quo_u = quo_u_ff;
   assign out_quo_v = quo_v_ff;

endmodule

// ===== rtl/cubemap_face_select.sv =====
// Top level of the cube-map face selection block: front stage and divider cell chain.
// An accepted direction word passes one front stage, then one divider cell per bit.
// Throughput is one word per cycle while the output takes words; every stage holds
// its own valid bit, so a stall at the output fills bubbles first and the chain
// keeps taking words until it is full.
// Reset is synchronous and active high; it clears the valid bits of all stages only.
module cubemap_face_select #(
   parameter int COORD_WIDTH = 16,
   parameter int UV_WIDTH    = 16
) (
   input  logic      clock,
   input  logic      reset,
   cfs_req_if.sink   req_if,
   cfs_rsp_if.source rsp_if
);

   localparam int CW = COORD_WIDTH;
   localparam int UV = UV_WIDTH;

   // Stage k of these arrays is the output of the front stage (k = 0) or of
   // divider cell k-1. The last entry feeds the response channel.
   logic [UV:0]          vld;
   logic [UV:0]          rdy;
   cfs_pkg::cfs_tag_type tag   [UV+1];
   logic [CW-1:0]        ma    [UV+1];
   logic [CW:0]          rem_u [UV+1];
   logic [CW:0]          rem_v [UV+1];
   logic [UV-1:0]        quo_u [UV+1];
   logic [UV-1:0]        quo_v [UV+1];

   // The front stage takes the absolute values, picks the major axis and face,
   // and forms the numerators sc + ma and tc + ma. They are the initial
   // remainders of the division by ma; the quotient starts empty.
   cfs_front #(
      .COORD_WIDTH (CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .dir_x     (req_if.dir_x),
      .dir_y     (req_if.dir_y),
      .dir_z     (req_if.dir_z),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .out_tag   (tag[0]),
      .out_ma    (ma[0]),
      .out_num_u (rem_u[0]),
      .out_num_v (rem_v[0])
   );

   assign quo_u[0] = '0;
   assign quo_v[0] = '0;

   // Each cell produces one quotient bit of floor(num * 2^(UV-1) / ma), most
   // significant bit first. The far-edge case num == 2*ma would need one more
   // bit; the front stage flags it and the output saturates instead.
   for (genvar k = 0; k < UV; k++) begin : g_cell
      cfs_div_cell #(
         .COORD_WIDTH (CW),
         .UV_WIDTH    (UV)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .in_tag    (tag[k]),
         .in_ma     (ma[k]),
         .in_rem_u  (rem_u[k]),
         .in_rem_v  (rem_v[k]),
         .in_quo_u  (quo_u[k]),
         .in_quo_v  (quo_v[k]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1]),
         .out_tag   (tag[k+1]),
         .out_ma    (ma[k+1]),
         .out_rem_u (rem_u[k+1]),
         .out_rem_v (rem_v[k+1]),
         .out_quo_u (quo_u[k+1]),
         .out_quo_v (quo_v[k+1])
      );
   end

   // The last cell's register is the output register. A zero vector forces
   // both coordinates to zero; a coordinate at the far edge saturates to all ones.
   assign rsp_if.valid = vld[UV];
   assign rdy[UV]      = rsp_if.ready;

   always_comb begin
      rsp_if.face_id        = tag[UV].face;
      rsp_if.zero_direction = tag[UV].zero;
      if (tag[UV].zero) begin
         rsp_if.tex_u = '0;
         rsp_if.tex_v = '0;
      end else begin
         rsp_if.tex_u = tag[UV].sat_u ? {UV{1'b1}} : quo_u[UV];
         rsp_if.tex_v = tag[UV].sat_v ? {UV{1'b1}} : quo_v[UV];
      end
   end

   // No word can appear at the output in the cycle right after reset.
   a_reset_empty : assert property (@(posedge clock) $past(reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

   // The tie rules send the zero vector to the negative z face.
   a_zero_face : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.zero_direction |-> rsp_if.face_id == cfs_pkg::FACE_NEG_Z)
      else $error("zero direction on a face other than negative z");

   // The zero flag set in the front stage must agree with the major magnitude.
   a_zero_flag : assert property (@(posedge clock) disable iff (reset)
      vld[0] |-> (tag[0].zero == (ma[0] == '0)))
      else $error("zero flag disagrees with major magnitude");

   // After the whole chain the u and v remainders stay below twice the divisor.
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      vld[UV] && !tag[UV].zero && !tag[UV].sat_u && !tag[UV].sat_v
      |-> (rem_u[UV] < {ma[UV], 1'b0}) && (rem_v[UV] < {ma[UV], 1'b0}))
      else $error("divider remainder out of range");

endmodule

// ===== tb/sv/cubemap_face_select_tb.sv =====
// Self-checking testbench for the cube-map face selection block with randomized handshakes.
module cubemap_face_select_tb;

   localparam int COORD_WIDTH = 16;
   localparam int UV_WIDTH    = 16;

   // Magnitude of the most negative component, which has no positive
   // counterpart in the same width.
   localparam int unsigned HALF_RANGE = 1 << (COORD_WIDTH - 1);
   localparam longint      UV_MAX     = (longint'(1) << UV_WIDTH) - 1;

   // The longest correct silence on both channels is made of a sender gap,
   // the pipe and a receiver stall. IDLE_LIMIT is well above that, so only
   // a hung block trips it.
   localparam int IDLE_LIMIT  = 600;
   // Cycles to keep watching after the last expected word, so that a stray
   // extra word from the pipe would still be caught.
   localparam int TAIL_CYCLES = 60;

   // One direction word waiting to be sent, with the cycles the sender idles
   // before it and whether it must wait for the pipe to drain first.
   typedef struct {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      int                            gap;
      bit                            drain;
   } direction_type;

   // One predicted face word.
   typedef struct {
      logic [cfs_pkg::FACE_WIDTH-1:0] face;
      logic [UV_WIDTH-1:0]            u;
      logic [UV_WIDTH-1:0]            v;
      logic                           zero;
   } face_word_type;

   logic clock;
   logic reset;

   cfs_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_bus ();
   cfs_rsp_if #(.UV_WIDTH(UV_WIDTH))       rsp_bus ();

   cubemap_face_select #(
      .COORD_WIDTH(COORD_WIDTH),
      .UV_WIDTH   (UV_WIDTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   direction_type directions_to_send[$];
   face_word_type pending_faces[$];
   int            mismatches = 0;
   int            directions_queued = 0;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Face coordinate (s/ma + 1)/2 as an unsigned fraction, truncated toward
   // zero. A minor component equal to +ma lands exactly on 1.0, which does not
   // fit, so it saturates to all ones. ma is always nonzero here.
   function automatic logic [UV_WIDTH-1:0] uv_fraction(input longint s, input longint ma);
      longint num;
      longint q;
      num = s + ma;
      if (num <= 0) return '0;
      q = (num * (longint'(1) << (UV_WIDTH - 1))) / ma;
      if (q > UV_MAX) return '1;
      return q[UV_WIDTH-1:0];
   endfunction

   // Picks the face by the axis of largest magnitude. X needs a strict win
   // over both others, Y a strict win over Z, and Z takes every remaining
   // tie. The minor components follow the usual cube-map table.
   function automatic face_word_type pick_face(input logic signed [COORD_WIDTH-1:0] dx,
                                               input logic signed [COORD_WIDTH-1:0] dy,
                                               input logic signed [COORD_WIDTH-1:0] dz);
      longint        x, y, z, ax, ay, az, ma, sc, tc;
      face_word_type w;
      x  = dx;
      y  = dy;
      z  = dz;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      if (ax > ay && ax > az) begin
         ma = ax;
         tc = -y;
         if (x > 0) begin
            w.face = cfs_pkg::FACE_POS_X;
            sc     = -z;
         end else begin
            w.face = cfs_pkg::FACE_NEG_X;
            sc     = z;
         end
      end else if (ay > az) begin
         ma = ay;
         sc = x;
         if (y > 0) begin
            w.face = cfs_pkg::FACE_POS_Y;
            tc     = z;
         end else begin
            w.face = cfs_pkg::FACE_NEG_Y;
            tc     = -z;
         end
      end else begin
         ma = az;
         tc = -y;
         if (z > 0) begin
            w.face = cfs_pkg::FACE_POS_Z;
            sc     = x;
         end else begin
            w.face = cfs_pkg::FACE_NEG_Z;
            sc     = -x;
         end
      end
      // A zero vector falls through every tie to the -z face and carries no
      // usable coordinates.
      if (ma == 0) begin
         w.u    = '0;
         w.v    = '0;
         w.zero = 1'b1;
      end else begin
         w.u    = uv_fraction(sc, ma);
         w.v    = uv_fraction(tc, ma);
         w.zero = 1'b0;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Queues one direction. Every third run of 40 words goes out back to back;
   // the others idle a random number of cycles before each word.
   task automatic add_direction(input int x, input int y, input int z, input bit drain);
      direction_type d;
      d.x     = COORD_WIDTH'(x);
      d.y     = COORD_WIDTH'(y);
      d.z     = COORD_WIDTH'(z);
      d.drain = drain;
      d.gap   = ((directions_queued / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
      directions_to_send.push_back(d);
      directions_queued++;
   endtask

   // A component of the given magnitude with a random sign. The full half
   // range only exists as a negative value.
   function automatic int with_sign(input int unsigned m);
      if (m >= HALF_RANGE || $urandom_range(0, 1) == 1) return -int'(m);
      return int'(m);
   endfunction

   // One of the values where the arithmetic is most likely to go wrong.
   function automatic int corner_value();
      unique case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return -1;
         3:       return int'(HALF_RANGE) - 1;
         4:       return -int'(HALF_RANGE);
         default: return -int'(HALF_RANGE) + 1;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Reset is held at the start and never again. The driver
   // and the monitor give the block's inputs known values at the first edge.
   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------

   // Sends the queued directions. A word is accepted at an edge where valid
   // and ready are both high; its face word is predicted right there from the
   // values on the bus. The next word is loaded only once the bus is free, and
   // each signal gets at most one nonblocking update per edge.
   always @(posedge clock) begin : direction_driver
      direction_type d;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.dir_x <= '0;
         req_bus.dir_y <= '0;
         req_bus.dir_z <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_faces.push_back(pick_face(req_bus.dir_x, req_bus.dir_y, req_bus.dir_z));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (directions_to_send.size() == 0 ||
                (directions_to_send[0].drain && pending_faces.size() != 0)) begin
               // Nothing left, or this word waits until the pipe is empty.
               req_bus.valid <= 1'b0;
            end else if (directions_to_send[0].gap > 0) begin
               directions_to_send[0].gap--;
               req_bus.valid <= 1'b0;
            end else begin
               d = directions_to_send.pop_front();
               req_bus.dir_x <= d.x;
               req_bus.dir_y <= d.y;
               req_bus.dir_z <= d.z;
               req_bus.valid <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------

   // Checks every accepted face word against the oldest prediction, field by
   // field, then draws how long to hold ready low before the next word. Every
   // third run of 40 words is taken with no stall at all.
   int face_words_seen = 0;
   int stall_left      = 0;

   always @(posedge clock) begin : face_monitor
      face_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_faces.size() == 0) begin
               $display("%0t: unexpected face word face=%0d u=%0d v=%0d zero=%0b", $time,
                        rsp_bus.face_id, rsp_bus.tex_u, rsp_bus.tex_v,
                        rsp_bus.zero_direction);
               mismatches++;
            end else begin
               want = pending_faces.pop_front();
               if (rsp_bus.face_id !== want.face) begin
                  $display("%0t: face_id expected %0d actual %0d", $time, want.face,
                           rsp_bus.face_id);
                  mismatches++;
               end
               if (rsp_bus.tex_u !== want.u) begin
                  $display("%0t: tex_u expected %0d actual %0d", $time, want.u,
                           rsp_bus.tex_u);
                  mismatches++;
               end
               if (rsp_bus.tex_v !== want.v) begin
                  $display("%0t: tex_v expected %0d actual %0d", $time, want.v,
                           rsp_bus.tex_v);
                  mismatches++;
               end
               if (rsp_bus.zero_direction !== want.zero) begin
                  $display("%0t: zero_direction expected %0b actual %0b", $time, want.zero,
                           rsp_bus.zero_direction);
                  mismatches++;
               end
            end
            face_words_seen++;
            stall_left = ((face_words_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------

   // Ends the run if neither channel moves a word for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------

   initial begin : stimulus
      int kind;
      int m;
      int a, b, c;
      int picked;

      // Directed words: each face, the zero vector, every kind of tie, the
      // far edge that saturates, and the most negative component.
      add_direction(0, 0, 0, 1'b0);                 // zero vector
      add_direction(1000, 200, -300, 1'b0);         // +x
      add_direction(-1000, 200, 300, 1'b0);         // -x
      add_direction(100, 2000, -50, 1'b0);          // +y
      add_direction(100, -2000, 50, 1'b0);          // -y
      add_direction(-10, 20, 3000, 1'b0);           // +z
      add_direction(10, 20, -3000, 1'b0);           // -z
      add_direction(500, 500, 10, 1'b0);            // x/y tie goes to y, u at the far edge
      add_direction(-500, 7, 500, 1'b0);            // x/z tie goes to z
      add_direction(3, -700, 700, 1'b0);            // y/z tie goes to z, v at the far edge
      add_direction(-900, -900, -900, 1'b0);        // three-way tie
      // The next one also waits for the pipe to drain before it goes out.
      add_direction(-32768, 32767, -32767, 1'b1);   // most negative x wins outright
      add_direction(0, -32768, 0, 1'b0);            // most negative y
      add_direction(32767, -32767, -32768, 1'b0);   // most negative z
      add_direction(-32768, -32768, -32768, 1'b0);  // all most negative, both edges
      add_direction(32767, 32767, 32767, 1'b0);     // all largest positive
      add_direction(1, 0, 0, 1'b0);
      add_direction(-1, 0, 0, 1'b0);
      add_direction(0, 0, -1, 1'b0);
      add_direction(0, 1, 0, 1'b0);
      add_direction(32767, -32768, 1, 1'b0);        // -y by one count of magnitude
      add_direction(-32768, 32767, 32767, 1'b0);
      add_direction(12345, -12345, 12344, 1'b0);    // x/y tie with z just below

      // Random words, mixed so that ties, zero vectors and saturation come
      // up often rather than once in a few billion.
      for (int i = 0; i < 500; i++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            // Fully random bit patterns.
            a = $signed(16'($urandom()));
            b = $signed(16'($urandom()));
            c = $signed(16'($urandom()));
         end else if (kind <= 5) begin
            // Tiny components: many ties and zero vectors.
            a = int'($urandom_range(0, 8)) - 4;
            b = int'($urandom_range(0, 8)) - 4;
            c = int'($urandom_range(0, 8)) - 4;
         end else if (kind == 6) begin
            a = corner_value();
            b = corner_value();
            c = corner_value();
         end else if (kind <= 8) begin
            // Two components of equal magnitude, the third equal or smaller.
            m = $urandom_range(1, HALF_RANGE);
            a = with_sign(m);
            b = with_sign(m);
            c = ($urandom_range(0, 3) == 0) ? with_sign(m) : with_sign($urandom_range(0, m - 1));
            picked = $urandom_range(0, 2);
            if (picked == 1) begin
               m = b;
               b = c;
               c = m;
            end else if (picked == 2) begin
               m = a;
               a = c;
               c = m;
            end
         end else begin
            // One clearly major axis with random minor components.
            m = $urandom_range(1, HALF_RANGE);
            a = with_sign(m);
            b = with_sign($urandom_range(0, m - 1));
            c = with_sign($urandom_range(0, m - 1));
            picked = $urandom_range(0, 2);
            if (picked == 1) begin
               m = a;
               a = b;
               b = m;
            end else if (picked == 2) begin
               m = a;
               a = c;
               c = m;
            end
         end
         add_direction(a, b, c, (i % 97) == 50);
      end

      // Wait until every word has gone out and every face word has come back,
      // then watch the output a while longer for anything extra.
      @(negedge reset);
      while (directions_to_send.size() != 0 || req_bus.valid || pending_faces.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_faces.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cfs_pkg.sv
rtl/cfs_if.sv
rtl/cfs_front.sv
rtl/cfs_div_cell.sv
rtl/cubemap_face_select.sv
tb/sv/cubemap_face_select_tb.sv
